@@ rtl/ecx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ecx_pkg;

	localparam int RAM_BYTES = 65536;
	localparam int ADDR_W = $clog2(RAM_BYTES);
	localparam logic [23:0] RESET_PC = 24'h008000;

	typedef logic [ADDR_W-1:0] addr_t;

	localparam logic [1:0] PRE_NONE = 2'd0;
	localparam logic [1:0] PRE_Y = 2'd1;
	localparam logic [1:0] PRE_EXT = 2'd2;

	localparam int FC = 0;
	localparam int FZ = 1;
	localparam int FN = 2;
	localparam int FI0 = 3;
	localparam int FH = 4;
	localparam int FI1 = 5;
	localparam int FV = 7;

	localparam logic [3:0] BIT_GROUP = 4'h1;

	localparam logic [7:0] OP_RRWA = 8'h01;
	localparam logic [7:0] OP_RLWA = 8'h02;
	localparam logic [7:0] OP_SRL_SP = 8'h04;
	localparam logic [7:0] OP_RRC_SP = 8'h06;
	localparam logic [7:0] OP_INC_SP = 8'h0C;
	localparam logic [7:0] OP_CLR_SP = 8'h0F;
	localparam logic [7:0] OP_CP_SP = 8'h11;
	localparam logic [7:0] OP_CPW_SP = 8'h13;
	localparam logic [7:0] OP_XOR_SP = 8'h18;
	localparam logic [7:0] OP_OR_SP = 8'h1A;
	localparam logic [7:0] OP_ADD_SP = 8'h1B;
	localparam logic [7:0] OP_ADDW_IMM = 8'h1C;
	localparam logic [7:0] OP_LDW_SP = 8'h1E;
	localparam logic [7:0] OP_STW_SP = 8'h1F;
	localparam logic [7:0] OP_JRA = 8'h20;
	localparam logic [7:0] OP_JRNC = 8'h24;
	localparam logic [7:0] OP_JRC = 8'h25;
	localparam logic [7:0] OP_JRNE = 8'h26;
	localparam logic [7:0] OP_JREQ = 8'h27;
	localparam logic [7:0] OP_CPL = 8'h43;
	localparam logic [7:0] OP_DEC = 8'h4A;
	localparam logic [7:0] OP_PUSH_IMM = 8'h4B;
	localparam logic [7:0] OP_TNZ = 8'h4D;
	localparam logic [7:0] OP_SUBSP = 8'h52;
	localparam logic [7:0] OP_SRLW = 8'h54;
	localparam logic [7:0] OP_ADDSP = 8'h5B;
	localparam logic [7:0] OP_INCW = 8'h5C;
	localparam logic [7:0] OP_CLRW = 8'h5F;
	localparam logic [7:0] OP_ST_SP = 8'h6B;
	localparam logic [7:0] OP_LD_SP = 8'h7B;
	localparam logic [7:0] OP_RET = 8'h81;
	localparam logic [7:0] OP_INT = 8'h82;
	localparam logic [7:0] OP_POP_A = 8'h84;
	localparam logic [7:0] OP_POPW = 8'h85;
	localparam logic [7:0] OP_PUSH_A = 8'h88;
	localparam logic [7:0] OP_PUSHW = 8'h89;
	localparam logic [7:0] OP_LDW_SPX = 8'h94;
	localparam logic [7:0] OP_LDW_XSP = 8'h96;
	localparam logic [7:0] OP_LD_XL = 8'h97;
	localparam logic [7:0] OP_SIM = 8'h9B;
	localparam logic [7:0] OP_CP_IMM = 8'hA1;
	localparam logic [7:0] OP_CPW_IMM = 8'hA3;
	localparam logic [7:0] OP_BCP_IMM = 8'hA5;
	localparam logic [7:0] OP_LD_IMM = 8'hA6;
	localparam logic [7:0] OP_XOR_IMM = 8'hA8;
	localparam logic [7:0] OP_OR_IMM = 8'hAA;
	localparam logic [7:0] OP_JPF = 8'hAC;
	localparam logic [7:0] OP_LDW_IMM = 8'hAE;
	localparam logic [7:0] OP_CPW_SHORT = 8'hB3;
	localparam logic [7:0] OP_LD_SHORT = 8'hB6;
	localparam logic [7:0] OP_LDW_SHORT = 8'hBE;
	localparam logic [7:0] OP_STW_SHORT = 8'hBF;
	localparam logic [7:0] OP_LD_LONG = 8'hC6;
	localparam logic [7:0] OP_ST_LONG = 8'hC7;
	localparam logic [7:0] OP_CALL = 8'hCD;
	localparam logic [7:0] OP_LDW_LONG = 8'hCE;
	localparam logic [7:0] OP_AND_IXB = 8'hE4;
	localparam logic [7:0] OP_ST_IXB = 8'hE7;
	localparam logic [7:0] OP_LDW_IXB = 8'hEE;
	localparam logic [7:0] OP_AND_IX = 8'hF4;
	localparam logic [7:0] OP_LD_IX = 8'hF6;
	localparam logic [7:0] OP_ST_IX = 8'hF7;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD0, ST_RD1, ST_RDW, ST_EXE, ST_WR1, ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] pre;
		logic [7:0] op;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
	} instr_t;

	typedef struct packed {
		logic [23:0] pc;
		logic [7:0]  a;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] sp;
		logic [7:0]  cc;
	} arch_t;

	typedef struct packed {
		logic       bad;
		logic [1:0] nrd;
		logic [1:0] nwr;
		addr_t      addr0;
		addr_t      addr1;
	} plan_t;

	typedef struct packed {
		arch_t      st;
		logic [7:0] wd0;
		logic [7:0] wd1;
	} exe_t;

	typedef struct packed {
		logic       en;
		logic       we;
		addr_t      addr;
		logic [7:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic [15:0] r;
		logic [7:0]  cc;
	} alu_t;

	function automatic logic maj(input logic p, input logic q, input logic s);
		return (p & q) | (q & s) | (p & s);
	endfunction

	function automatic logic brw(input logic p, input logic q, input logic s);
		return (~p & q) | (~p & s) | (p & q & s);
	endfunction

	function automatic logic [7:0] put_zn(input logic [7:0] cc, input logic [15:0] r,
			input logic w);
		logic [7:0] c;
		c = cc;
		c[FZ] = w ? (r == 16'h0000) : (r[7:0] == 8'h00);
		c[FN] = w ? r[15] : r[7];
		return c;
	endfunction

	function automatic alu_t f_add(input logic [7:0] cc, input logic [15:0] a,
			input logic [15:0] b, input logic w);
		logic [15:0] s;
		logic ct, cu;
		alu_t o;
		s = a + b;
		if (!w) begin
			s[15:8] = 8'h00;
		end
		ct = w ? maj(a[15], b[15], ~s[15]) : maj(a[7], b[7], ~s[7]);
		cu = w ? maj(a[14], b[14], ~s[14]) : maj(a[6], b[6], ~s[6]);
		o.r = s;
		o.cc = put_zn(cc, s, w);
		o.cc[FC] = ct;
		o.cc[FH] = w ? maj(a[7], b[7], ~s[7]) : maj(a[3], b[3], ~s[3]);
		o.cc[FV] = ct ^ cu;
		return o;
	endfunction

	function automatic alu_t f_cmp(input logic [7:0] cc, input logic [15:0] a,
			input logic [15:0] b, input logic w);
		logic [15:0] s;
		logic bt, bu;
		alu_t o;
		s = a - b;
		if (!w) begin
			s[15:8] = 8'h00;
		end
		bt = w ? brw(a[15], b[15], s[15]) : brw(a[7], b[7], s[7]);
		bu = w ? brw(a[14], b[14], s[14]) : brw(a[6], b[6], s[6]);
		o.r = s;
		o.cc = put_zn(cc, s, w);
		o.cc[FC] = bt;
		o.cc[FV] = bt ^ bu;
		return o;
	endfunction

	function automatic logic is_main(input logic [7:0] op);
		case (op) inside
			OP_RRWA, OP_RLWA, OP_SRL_SP, OP_RRC_SP, OP_INC_SP, OP_CLR_SP, OP_CP_SP,
			OP_CPW_SP, OP_XOR_SP, OP_OR_SP, OP_ADD_SP, OP_ADDW_IMM, OP_LDW_SP, OP_STW_SP,
			OP_JRA, OP_JRNC, OP_JRC, OP_JRNE, OP_JREQ, OP_CPL, OP_DEC, OP_PUSH_IMM,
			OP_TNZ, OP_SUBSP, OP_SRLW, OP_ADDSP, OP_INCW, OP_CLRW, OP_ST_SP, OP_LD_SP,
			OP_RET, OP_INT, OP_POP_A, OP_POPW, OP_PUSH_A, OP_PUSHW, OP_LDW_SPX,
			OP_LDW_XSP, OP_LD_XL, OP_SIM, OP_CP_IMM, OP_CPW_IMM, OP_BCP_IMM, OP_LD_IMM,
			OP_XOR_IMM, OP_OR_IMM, OP_JPF, OP_LDW_IMM, OP_CPW_SHORT, OP_LD_SHORT,
			OP_LDW_SHORT, OP_STW_SHORT, OP_LD_LONG, OP_ST_LONG, OP_CALL, OP_LDW_LONG,
			OP_AND_IXB, OP_ST_IXB, OP_LDW_IXB, OP_AND_IX, OP_LD_IX, OP_ST_IX: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic is_yvar(input logic [7:0] op);
		case (op) inside
			OP_RRWA, OP_RLWA, OP_SRLW, OP_INCW, OP_CLRW, OP_POPW, OP_PUSHW, OP_LDW_SPX,
			OP_LDW_XSP, OP_LD_XL, OP_CPW_IMM, OP_LDW_IMM, OP_CPW_SHORT, OP_LDW_SHORT,
			OP_STW_SHORT, OP_LDW_LONG, OP_AND_IXB, OP_LDW_IXB, OP_AND_IX, OP_LD_IX,
			OP_ST_IX: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

endpackage
`default_nettype wire

@@ rtl/ecx_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ecx_ram #(
	parameter int DEPTH = 65536,
	parameter int ADDR_W = 16,
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/ecx_dec.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ecx_dec (
	input  wire ecx_pkg::instr_t ins,
	input  wire ecx_pkg::arch_t  arch,
	output ecx_pkg::plan_t       plan
);
	logic [15:0] ix;
	logic [16:0] sp_sum, ix_sum;
	ecx_pkg::addr_t sp_b1, ix_b1, sp_a;

	always_comb begin
		ix = (ins.pre == ecx_pkg::PRE_Y) ? arch.y : arch.x;
		sp_sum = {1'b0, arch.sp} + {9'h000, ins.b1};
		ix_sum = {1'b0, ix} + {9'h000, ins.b1};
		sp_b1 = sp_sum[ecx_pkg::ADDR_W-1:0];
		ix_b1 = ix_sum[ecx_pkg::ADDR_W-1:0];
		sp_a = arch.sp[ecx_pkg::ADDR_W-1:0];
	end

	always_comb begin
		plan.nrd = 2'd0;
		plan.nwr = 2'd0;
		plan.addr0 = sp_b1;
		unique case (ins.pre)
			ecx_pkg::PRE_NONE: plan.bad = !ecx_pkg::is_main(ins.op);
			ecx_pkg::PRE_Y: plan.bad = !ecx_pkg::is_yvar(ins.op);
			ecx_pkg::PRE_EXT: plan.bad = !(ins.op[7:4] == ecx_pkg::BIT_GROUP ||
				ins.op == ecx_pkg::OP_CLRW);
			default: plan.bad = 1'b1;
		endcase
		if (plan.bad) begin
			plan.nrd = 2'd0;
		end else if (ins.pre == ecx_pkg::PRE_EXT) begin
			plan.addr0 = ecx_pkg::addr_t'({ins.b1, ins.b2});
			plan.nwr = 2'd1;
			plan.nrd = (ins.op == ecx_pkg::OP_CLRW) ? 2'd0 : 2'd1;
		end else begin
			unique case (ins.op) inside
				ecx_pkg::OP_SRL_SP, ecx_pkg::OP_RRC_SP, ecx_pkg::OP_INC_SP: begin
					plan.nrd = 2'd1;
					plan.nwr = 2'd1;
				end
				ecx_pkg::OP_CLR_SP, ecx_pkg::OP_ST_SP: plan.nwr = 2'd1;
				ecx_pkg::OP_CP_SP, ecx_pkg::OP_XOR_SP, ecx_pkg::OP_OR_SP,
				ecx_pkg::OP_ADD_SP, ecx_pkg::OP_LD_SP: plan.nrd = 2'd1;
				ecx_pkg::OP_CPW_SP, ecx_pkg::OP_LDW_SP: plan.nrd = 2'd2;
				ecx_pkg::OP_STW_SP: plan.nwr = 2'd2;
				ecx_pkg::OP_PUSH_IMM, ecx_pkg::OP_PUSH_A: begin
					plan.addr0 = sp_a;
					plan.nwr = 2'd1;
				end
				ecx_pkg::OP_PUSHW, ecx_pkg::OP_CALL: begin
					plan.addr0 = sp_a;
					plan.nwr = 2'd2;
				end
				ecx_pkg::OP_RET, ecx_pkg::OP_POPW: begin
					plan.addr0 = sp_a + ecx_pkg::addr_t'(1);
					plan.nrd = 2'd2;
				end
				ecx_pkg::OP_POP_A: begin
					plan.addr0 = sp_a + ecx_pkg::addr_t'(1);
					plan.nrd = 2'd1;
				end
				ecx_pkg::OP_CPW_SHORT, ecx_pkg::OP_LDW_SHORT: begin
					plan.addr0 = ecx_pkg::addr_t'(ins.b1);
					plan.nrd = 2'd2;
				end
				ecx_pkg::OP_STW_SHORT: begin
					plan.addr0 = ecx_pkg::addr_t'(ins.b1);
					plan.nwr = 2'd2;
				end
				ecx_pkg::OP_LD_SHORT: begin
					plan.addr0 = ecx_pkg::addr_t'(ins.b1);
					plan.nrd = 2'd1;
				end
				ecx_pkg::OP_LD_LONG: begin
					plan.addr0 = ecx_pkg::addr_t'({ins.b1, ins.b2});
					plan.nrd = 2'd1;
				end
				ecx_pkg::OP_ST_LONG: begin
					plan.addr0 = ecx_pkg::addr_t'({ins.b1, ins.b2});
					plan.nwr = 2'd1;
				end
				ecx_pkg::OP_LDW_LONG: begin
					plan.addr0 = ecx_pkg::addr_t'({ins.b1, ins.b2});
					plan.nrd = 2'd2;
				end
				ecx_pkg::OP_AND_IXB: begin
					plan.addr0 = ix_b1;
					plan.nrd = 2'd1;
				end
				ecx_pkg::OP_ST_IXB: begin
					plan.addr0 = ix_b1;
					plan.nwr = 2'd1;
				end
				ecx_pkg::OP_LDW_IXB: begin
					plan.addr0 = ix_b1;
					plan.nrd = 2'd2;
				end
				ecx_pkg::OP_AND_IX, ecx_pkg::OP_LD_IX: begin
					plan.addr0 = ix[ecx_pkg::ADDR_W-1:0];
					plan.nrd = 2'd1;
				end
				ecx_pkg::OP_ST_IX: begin
					plan.addr0 = ix[ecx_pkg::ADDR_W-1:0];
					plan.nwr = 2'd1;
				end
				default: plan.nrd = 2'd0;
			endcase
		end
		if (!plan.bad && (ins.op == ecx_pkg::OP_PUSHW || ins.op == ecx_pkg::OP_CALL) &&
				ins.pre != ecx_pkg::PRE_EXT) begin
			plan.addr1 = plan.addr0 - ecx_pkg::addr_t'(1);
		end else begin
			plan.addr1 = plan.addr0 + ecx_pkg::addr_t'(1);
		end
	end
endmodule
`default_nettype wire

@@ rtl/ecx_exe.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ecx_exe (
	input  wire ecx_pkg::instr_t ins,
	input  wire ecx_pkg::arch_t  arch,
	input  wire logic            bad,
	input  wire logic [7:0]      d0,
	input  wire logic [7:0]      d1,
	output ecx_pkg::exe_t        res
);
	logic [15:0] ix, imm, mw, v;
	logic [2:0]  len;
	logic [23:0] seq_pc, npc;
	logic        jump;
	logic [7:0]  cc, msk;
	ecx_pkg::alu_t al;

	always_comb begin
		ix = (ins.pre == ecx_pkg::PRE_Y) ? arch.y : arch.x;
		imm = {ins.b1, ins.b2};
		mw = {d0, d1};
		len = (ins.pre != ecx_pkg::PRE_NONE) ? 3'd2 : 3'd1;
		cc = arch.cc;
		jump = 1'b0;
		npc = arch.pc;
		res = '0;
		res.st = arch;
		msk = 8'h01 << ins.op[3:1];
		v = 16'h0000;
		al = '0;
		if (!bad && ins.pre == ecx_pkg::PRE_EXT) begin
			len = 3'd4;
			if (ins.op == ecx_pkg::OP_CLRW) begin
				cc[ecx_pkg::FZ] = 1'b1;
				cc[ecx_pkg::FN] = 1'b0;
				res.wd0 = 8'h00;
			end else begin
				res.wd0 = ins.op[0] ? (d0 & ~msk) : (d0 | msk);
			end
		end else if (!bad) begin
			unique case (ins.op) inside
				ecx_pkg::OP_RRWA: begin
					v = {res.st.a, ix[15:8]};
					cc = ecx_pkg::put_zn(cc, v, 1'b1);
					res.st.a = ix[7:0];
					ix = v;
				end
				ecx_pkg::OP_RLWA: begin
					v = {ix[7:0], res.st.a};
					cc = ecx_pkg::put_zn(cc, v, 1'b1);
					res.st.a = ix[15:8];
					ix = v;
				end
				ecx_pkg::OP_SRL_SP, ecx_pkg::OP_RRC_SP: begin
					res.wd0 = {(ins.op == ecx_pkg::OP_RRC_SP) & cc[ecx_pkg::FC], d0[7:1]};
					cc[ecx_pkg::FC] = d0[0];
					cc = ecx_pkg::put_zn(cc, {8'h00, res.wd0}, 1'b0);
					len = len + 3'd1;
				end
				ecx_pkg::OP_INC_SP: begin
					al = ecx_pkg::f_add(cc, {8'h00, d0}, 16'h0001, 1'b0);
					cc = {al.cc[7:5], cc[ecx_pkg::FH], al.cc[3:1], cc[ecx_pkg::FC]};
					res.wd0 = al.r[7:0];
					len = len + 3'd1;
				end
				ecx_pkg::OP_CLR_SP: begin
					cc[ecx_pkg::FZ] = 1'b1;
					cc[ecx_pkg::FN] = 1'b0;
					res.wd0 = 8'h00;
					len = len + 3'd1;
				end
				ecx_pkg::OP_CP_SP: begin
					al = ecx_pkg::f_cmp(cc, {8'h00, res.st.a}, {8'h00, d0}, 1'b0);
					cc = al.cc;
					len = len + 3'd1;
				end
				ecx_pkg::OP_CPW_SP, ecx_pkg::OP_CPW_SHORT: begin
					al = ecx_pkg::f_cmp(cc, ix, mw, 1'b1);
					cc = al.cc;
					len = len + 3'd1;
				end
				ecx_pkg::OP_XOR_SP, ecx_pkg::OP_XOR_IMM: begin
					res.st.a = res.st.a ^ ((ins.op == ecx_pkg::OP_XOR_SP) ? d0 : ins.b1);
					cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a}, 1'b0);
					len = len + 3'd1;
				end
				ecx_pkg::OP_OR_SP, ecx_pkg::OP_OR_IMM: begin
					res.st.a = res.st.a | ((ins.op == ecx_pkg::OP_OR_SP) ? d0 : ins.b1);
					cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a}, 1'b0);
					len = len + 3'd1;
				end
				ecx_pkg::OP_ADD_SP: begin
					al = ecx_pkg::f_add(cc, {8'h00, res.st.a}, {8'h00, d0}, 1'b0);
					cc = al.cc;
					res.st.a = al.r[7:0];
					len = len + 3'd1;
				end
				ecx_pkg::OP_ADDW_IMM: begin
					al = ecx_pkg::f_add(cc, ix, imm, 1'b1);
					cc = al.cc;
					ix = al.r;
					len = len + 3'd2;
				end
				ecx_pkg::OP_LDW_SP, ecx_pkg::OP_LDW_SHORT, ecx_pkg::OP_LDW_IXB: begin
					cc = ecx_pkg::put_zn(cc, mw, 1'b1);
					ix = mw;
					len = len + 3'd1;
				end
				ecx_pkg::OP_LDW_LONG: begin
					cc = ecx_pkg::put_zn(cc, mw, 1'b1);
					ix = mw;
					len = len + 3'd2;
				end
				ecx_pkg::OP_STW_SP, ecx_pkg::OP_STW_SHORT: begin
					cc = ecx_pkg::put_zn(cc, ix, 1'b1);
					res.wd0 = ix[15:8];
					res.wd1 = ix[7:0];
					len = len + 3'd1;
				end
				ecx_pkg::OP_JRA, ecx_pkg::OP_JRNC, ecx_pkg::OP_JRC, ecx_pkg::OP_JRNE,
				ecx_pkg::OP_JREQ: begin
					len = len + 3'd1;
					jump = (ins.op == ecx_pkg::OP_JRA) ||
						(ins.op == ecx_pkg::OP_JRNC && !cc[ecx_pkg::FC]) ||
						(ins.op == ecx_pkg::OP_JRC && cc[ecx_pkg::FC]) ||
						(ins.op == ecx_pkg::OP_JRNE && !cc[ecx_pkg::FZ]) ||
						(ins.op == ecx_pkg::OP_JREQ && cc[ecx_pkg::FZ]);
					npc = arch.pc + {21'h000000, len} + {{16{ins.b1[7]}}, ins.b1};
				end
				ecx_pkg::OP_CPL: begin
					res.st.a = ~res.st.a;
					cc[ecx_pkg::FC] = 1'b1;
					cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a}, 1'b0);
				end
				ecx_pkg::OP_DEC: begin
					al = ecx_pkg::f_cmp(cc, {8'h00, res.st.a}, 16'h0001, 1'b0);
					cc = {al.cc[7:1], cc[ecx_pkg::FC]};
					res.st.a = al.r[7:0];
				end
				ecx_pkg::OP_PUSH_IMM: begin
					res.wd0 = ins.b1;
					res.st.sp = arch.sp - 16'h0001;
					len = len + 3'd1;
				end
				ecx_pkg::OP_TNZ: cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a}, 1'b0);
				ecx_pkg::OP_SUBSP: begin
					res.st.sp = arch.sp - {8'h00, ins.b1};
					len = len + 3'd1;
				end
				ecx_pkg::OP_SRLW: begin
					cc[ecx_pkg::FC] = ix[0];
					ix = {1'b0, ix[15:1]};
					cc = ecx_pkg::put_zn(cc, ix, 1'b1);
				end
				ecx_pkg::OP_ADDSP: begin
					res.st.sp = arch.sp + {8'h00, ins.b1};
					len = len + 3'd1;
				end
				ecx_pkg::OP_INCW: begin
					al = ecx_pkg::f_add(cc, ix, 16'h0001, 1'b1);
					cc = {al.cc[7:5], cc[ecx_pkg::FH], al.cc[3:1], cc[ecx_pkg::FC]};
					ix = al.r;
				end
				ecx_pkg::OP_CLRW: begin
					cc[ecx_pkg::FZ] = 1'b1;
					cc[ecx_pkg::FN] = 1'b0;
					ix = 16'h0000;
				end
				ecx_pkg::OP_ST_SP, ecx_pkg::OP_ST_IXB: begin
					cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a}, 1'b0);
					res.wd0 = res.st.a;
					len = len + 3'd1;
				end
				ecx_pkg::OP_ST_LONG: begin
					cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a}, 1'b0);
					res.wd0 = res.st.a;
					len = len + 3'd2;
				end
				ecx_pkg::OP_ST_IX: begin
					cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a}, 1'b0);
					res.wd0 = res.st.a;
				end
				ecx_pkg::OP_LD_SP, ecx_pkg::OP_LD_SHORT: begin
					res.st.a = d0;
					cc = ecx_pkg::put_zn(cc, {8'h00, d0}, 1'b0);
					len = len + 3'd1;
				end
				ecx_pkg::OP_LD_LONG: begin
					res.st.a = d0;
					cc = ecx_pkg::put_zn(cc, {8'h00, d0}, 1'b0);
					len = len + 3'd2;
				end
				ecx_pkg::OP_LD_IX: begin
					res.st.a = d0;
					cc = ecx_pkg::put_zn(cc, {8'h00, d0}, 1'b0);
				end
				ecx_pkg::OP_RET: begin
					seq_pc = arch.pc + {21'h000000, len};
					npc = {seq_pc[23:16], mw};
					jump = 1'b1;
					res.st.sp = arch.sp + 16'h0002;
				end
				ecx_pkg::OP_INT, ecx_pkg::OP_JPF: begin
					npc = {ins.b1, ins.b2, ins.b3};
					jump = 1'b1;
				end
				ecx_pkg::OP_POP_A: begin
					res.st.a = d0;
					res.st.sp = arch.sp + 16'h0001;
				end
				ecx_pkg::OP_POPW: begin
					ix = mw;
					res.st.sp = arch.sp + 16'h0002;
				end
				ecx_pkg::OP_PUSH_A: begin
					res.wd0 = res.st.a;
					res.st.sp = arch.sp - 16'h0001;
				end
				ecx_pkg::OP_PUSHW: begin
					res.wd0 = ix[7:0];
					res.wd1 = ix[15:8];
					res.st.sp = arch.sp - 16'h0002;
				end
				ecx_pkg::OP_LDW_SPX: res.st.sp = ix;
				ecx_pkg::OP_LDW_XSP: ix = arch.sp;
				ecx_pkg::OP_LD_XL: ix = {ix[15:8], res.st.a};
				ecx_pkg::OP_SIM: begin
					cc[ecx_pkg::FI0] = 1'b1;
					cc[ecx_pkg::FI1] = 1'b1;
				end
				ecx_pkg::OP_CP_IMM: begin
					al = ecx_pkg::f_cmp(cc, {8'h00, res.st.a}, {8'h00, ins.b1}, 1'b0);
					cc = al.cc;
					len = len + 3'd1;
				end
				ecx_pkg::OP_CPW_IMM: begin
					al = ecx_pkg::f_cmp(cc, ix, imm, 1'b1);
					cc = al.cc;
					len = len + 3'd2;
				end
				ecx_pkg::OP_BCP_IMM: begin
					cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a & ins.b1}, 1'b0);
					len = len + 3'd1;
				end
				ecx_pkg::OP_LD_IMM: begin
					res.st.a = ins.b1;
					cc = ecx_pkg::put_zn(cc, {8'h00, ins.b1}, 1'b0);
					len = len + 3'd1;
				end
				ecx_pkg::OP_LDW_IMM: begin
					ix = imm;
					cc = ecx_pkg::put_zn(cc, imm, 1'b1);
					len = len + 3'd2;
				end
				ecx_pkg::OP_CALL: begin
					len = len + 3'd2;
					seq_pc = arch.pc + {21'h000000, len};
					res.wd0 = seq_pc[7:0];
					res.wd1 = seq_pc[15:8];
					res.st.sp = arch.sp - 16'h0002;
					npc = {seq_pc[23:16], imm};
					jump = 1'b1;
				end
				ecx_pkg::OP_AND_IXB: begin
					res.st.a = res.st.a & d0;
					cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a}, 1'b0);
					len = len + 3'd1;
				end
				ecx_pkg::OP_AND_IX: begin
					res.st.a = res.st.a & d0;
					cc = ecx_pkg::put_zn(cc, {8'h00, res.st.a}, 1'b0);
				end
				default: len = len;
			endcase
		end
		seq_pc = arch.pc + {21'h000000, len};
		if (!bad) begin
			res.st.pc = jump ? npc : seq_pc;
			res.st.cc = cc;
			if (ins.pre == ecx_pkg::PRE_Y) begin
				res.st.y = ix;
			end else begin
				res.st.x = ix;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/eight_bit_cpu_execute.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_data (reset_pc, also loads pc)
// item      in         item_valid / item_stall prefix_code, opcode, operand bytes
// result    out        result_valid / result_stall next_pc .. bad_opcode
// one instruction steps through hand-over, read issue, execute and done on the single
// ram port, plus a read state per ram read byte and a state for a second write byte
// a stalled result holds the sequencer in done for as long as the stall lasts
// after reset the ram is swept to zero, every address in turn, items stalled meanwhile
// an input buffer and a result register let the next word in while a result waits
// cfg is taken only while the sequencer is idle and no word is buffered
module eight_bit_cpu_execute (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [23:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  prefix_code,
	input  wire logic [7:0]  opcode,
	input  wire logic [7:0]  operand_byte_one,
	input  wire logic [7:0]  operand_byte_two,
	input  wire logic [7:0]  operand_byte_three,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [23:0]      next_pc,
	output logic [7:0]       acc_value,
	output logic [15:0]      x_value,
	output logic [15:0]      y_value,
	output logic [15:0]      sp_value,
	output logic [7:0]       flags_value,
	output logic             bad_opcode
);
	ecx_pkg::state_t st_q, st_nxt;
	ecx_pkg::instr_t inb_q, ins_q;
	ecx_pkg::arch_t arch_q, res_q;
	ecx_pkg::plan_t plan;
	ecx_pkg::exe_t exe;
	ecx_pkg::mem_req_t core_req, req;
	ecx_pkg::addr_t clr_cnt_q, wa1_q;
	logic inb_v_q, clearing_q, res_v_q, bad_q, res_bad_q;
	logic [7:0] d0_q, d1_q, wd1_q, rdata;
	logic item_acc, take, out_free, res_load;

	assign cfg_ready = (st_q == ecx_pkg::ST_IDLE) & ~inb_v_q;
	assign item_stall = inb_v_q | clearing_q;
	assign item_acc = item_valid & ~item_stall;
	assign take = (st_q == ecx_pkg::ST_IDLE) & inb_v_q;
	assign out_free = ~res_v_q | ~result_stall;
	assign res_load = (st_q == ecx_pkg::ST_DONE) & out_free;

	ecx_dec u_dec (.ins(ins_q), .arch(arch_q), .plan(plan));

	ecx_exe u_exe (
		.ins(ins_q), .arch(arch_q), .bad(plan.bad), .d0(d0_q), .d1(d1_q), .res(exe)
	);

	ecx_ram #(
		.DEPTH(ecx_pkg::RAM_BYTES), .ADDR_W(ecx_pkg::ADDR_W), .DATA_W(8)
	) u_ram (
		.clk(clk), .en(req.en), .we(req.we), .addr(req.addr), .wdata(req.wdata),
		.rdata(rdata)
	);

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			ecx_pkg::ST_IDLE: if (take) st_nxt = ecx_pkg::ST_RD0;
			ecx_pkg::ST_RD0: begin
				if (plan.nrd == 2'd0) begin
					st_nxt = ecx_pkg::ST_EXE;
				end else if (plan.nrd == 2'd2) begin
					st_nxt = ecx_pkg::ST_RD1;
				end else begin
					st_nxt = ecx_pkg::ST_RDW;
				end
			end
			ecx_pkg::ST_RD1: st_nxt = ecx_pkg::ST_RDW;
			ecx_pkg::ST_RDW: st_nxt = ecx_pkg::ST_EXE;
			ecx_pkg::ST_EXE: st_nxt = (plan.nwr == 2'd2) ? ecx_pkg::ST_WR1 : ecx_pkg::ST_DONE;
			ecx_pkg::ST_WR1: st_nxt = ecx_pkg::ST_DONE;
			ecx_pkg::ST_DONE: if (out_free) st_nxt = ecx_pkg::ST_IDLE;
			default: st_nxt = ecx_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		core_req = '0;
		unique case (st_q)
			ecx_pkg::ST_RD0: begin
				core_req.en = plan.nrd != 2'd0;
				core_req.addr = plan.addr0;
			end
			ecx_pkg::ST_RD1: begin
				core_req.en = 1'b1;
				core_req.addr = plan.addr1;
			end
			ecx_pkg::ST_EXE: begin
				core_req.en = plan.nwr != 2'd0;
				core_req.we = 1'b1;
				core_req.addr = plan.addr0;
				core_req.wdata = exe.wd0;
			end
			ecx_pkg::ST_WR1: begin
				core_req.en = 1'b1;
				core_req.we = 1'b1;
				core_req.addr = wa1_q;
				core_req.wdata = wd1_q;
			end
			default: core_req = '0;
		endcase
		if (clearing_q) begin
			req.en = 1'b1;
			req.we = 1'b1;
			req.addr = clr_cnt_q;
			req.wdata = 8'h00;
		end else begin
			req = core_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ecx_pkg::ST_IDLE;
			inb_v_q <= 1'b0;
			res_v_q <= 1'b0;
			clearing_q <= 1'b1;
			clr_cnt_q <= '0;
			arch_q <= '{pc: ecx_pkg::RESET_PC, default: '0};
		end else begin
			st_q <= st_nxt;
			if (item_acc) begin
				inb_v_q <= 1'b1;
			end else if (take) begin
				inb_v_q <= 1'b0;
			end
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (!result_stall) begin
				res_v_q <= 1'b0;
			end
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + ecx_pkg::addr_t'(1);
				if (clr_cnt_q == ecx_pkg::addr_t'(ecx_pkg::RAM_BYTES - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (cfg_valid && cfg_ready) begin
				arch_q.pc <= cfg_data;
			end else if (st_q == ecx_pkg::ST_EXE) begin
				arch_q <= exe.st;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			inb_q <= {prefix_code, opcode, operand_byte_one, operand_byte_two,
				operand_byte_three};
		end
		if (take) begin
			ins_q <= inb_q;
		end
		if (st_q == ecx_pkg::ST_RD1) begin
			d0_q <= rdata;
		end
		if (st_q == ecx_pkg::ST_RDW) begin
			if (plan.nrd == 2'd2) begin
				d1_q <= rdata;
			end else begin
				d0_q <= rdata;
			end
		end
		if (st_q == ecx_pkg::ST_EXE) begin
			wa1_q <= plan.addr1;
			wd1_q <= exe.wd1;
			bad_q <= plan.bad;
		end
		if (res_load) begin
			res_q <= arch_q;
			res_bad_q <= bad_q;
		end
	end

	assign result_valid = res_v_q;
	assign next_pc = res_q.pc;
	assign acc_value = res_q.a;
	assign x_value = res_q.x;
	assign y_value = res_q.y;
	assign sp_value = res_q.sp;
	assign flags_value = res_q.cc;
	assign bad_opcode = res_bad_q;

	a_busy_not_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ecx_pkg::ST_IDLE |-> !clearing_q)
		else $error("sequencer active during ram sweep");

	a_wr1_after_exe: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ecx_pkg::ST_WR1 |-> $past(st_q) == ecx_pkg::ST_EXE)
		else $error("second write byte out of order");

	a_bad_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ecx_pkg::ST_EXE && plan.bad && !cfg_valid) |=> arch_q == $past(arch_q))
		else $error("unimplemented opcode changed state");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(st_q) == ecx_pkg::ST_DONE)
		else $error("result word without finished instruction");
endmodule
`default_nettype wire

@@ dv/ecx_execute_checker.sv @@
`timescale 1ns / 1ps
module ecx_execute_checker
	import ecx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [23:0] cfg_data,
	input  wire logic        item_valid,
	input  wire logic        item_stall,
	input  wire logic [1:0]  prefix_code,
	input  wire logic [7:0]  opcode,
	input  wire logic [7:0]  operand_byte_one,
	input  wire logic [7:0]  operand_byte_two,
	input  wire logic [7:0]  operand_byte_three,
	input  wire logic        result_valid,
	input  wire logic        result_stall,
	input  wire logic [23:0] next_pc,
	input  wire logic [7:0]  acc_value,
	input  wire logic [15:0] x_value,
	input  wire logic [15:0] y_value,
	input  wire logic [15:0] sp_value,
	input  wire logic [7:0]  flags_value,
	input  wire logic        bad_opcode,
	output int               mismatches,
	output int               outstanding
);

	typedef struct {
		logic [23:0] pc;
		logic [7:0]  a;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] sp;
		logic [7:0]  cc;
		logic        bad;
	} cpu_view_t;

	cpu_view_t   cpu_state_q[$];
	logic [23:0] boot_pc;
	logic [23:0] pc_r;
	logic [7:0]  acc_r;
	logic [15:0] ix_r;
	logic [15:0] iy_r;
	logic [15:0] sp_r;
	logic [7:0]  cc_r;
	logic [7:0]  ram [0:RAM_BYTES-1];

	initial begin
		mismatches = 0;
	end

	assign outstanding = cpu_state_q.size();

	function automatic logic [7:0] ram_rd(input int unsigned addr);
		return ram[addr % RAM_BYTES];
	endfunction

	function automatic void ram_wr(input int unsigned addr, input logic [7:0] val);
		ram[addr % RAM_BYTES] = val;
	endfunction

	function automatic logic [15:0] ram_rd16(input int unsigned addr);
		return {ram_rd(addr), ram_rd(addr + 1)};
	endfunction

	function automatic void ram_wr16(input int unsigned addr, input logic [15:0] val);
		ram_wr(addr, val[15:8]);
		ram_wr(addr + 1, val[7:0]);
	endfunction

	function automatic void push_byte(input logic [7:0] val);
		ram_wr(sp_r, val);
		sp_r = sp_r - 16'd1;
	endfunction

	function automatic logic [7:0] pop_byte();
		sp_r = sp_r + 16'd1;
		return ram_rd(sp_r);
	endfunction

	function automatic void push_word(input logic [15:0] val);
		push_byte(val[7:0]);
		push_byte(val[15:8]);
	endfunction

	function automatic logic [15:0] pop_word();
		logic [7:0] hi;
		hi = pop_byte();
		return {hi, pop_byte()};
	endfunction

	function automatic void set_zn(input logic [15:0] r, input logic wide);
		cc_r[FZ] = wide ? (r == 16'h0000) : (r[7:0] == 8'h00);
		cc_r[FN] = wide ? r[15] : r[7];
	endfunction

	function automatic logic carry_bit(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] r, input int k);
		return (a[k] & b[k]) | (b[k] & ~r[k]) | (a[k] & ~r[k]);
	endfunction

	function automatic logic borrow_bit(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] r, input int k);
		return (~a[k] & b[k]) | (~a[k] & r[k]) | (a[k] & b[k] & r[k]);
	endfunction

	function automatic logic [15:0] alu_add(input logic [15:0] a, input logic [15:0] b,
			input logic wide);
		logic [15:0] r;
		int t;
		t = wide ? 15 : 7;
		r = a + b;
		if (!wide) begin
			r[15:8] = 8'h00;
		end
		cc_r[FC] = carry_bit(a, b, r, t);
		set_zn(r, wide);
		cc_r[FH] = carry_bit(a, b, r, wide ? 7 : 3);
		cc_r[FV] = carry_bit(a, b, r, t) ^ carry_bit(a, b, r, t - 1);
		return r;
	endfunction

	function automatic void alu_cmp(input logic [15:0] a, input logic [15:0] b,
			input logic wide);
		logic [15:0] r;
		int t;
		t = wide ? 15 : 7;
		r = a - b;
		if (!wide) begin
			r[15:8] = 8'h00;
		end
		cc_r[FC] = borrow_bit(a, b, r, t);
		set_zn(r, wide);
		cc_r[FV] = borrow_bit(a, b, r, t) ^ borrow_bit(a, b, r, t - 1);
	endfunction

	function automatic logic [15:0] alu_inc(input logic [15:0] a, input logic wide);
		logic [15:0] r;
		int t;
		t = wide ? 15 : 7;
		r = a + 16'd1;
		if (!wide) begin
			r[15:8] = 8'h00;
		end
		set_zn(r, wide);
		cc_r[FV] = carry_bit(a, 16'd1, r, t) ^ carry_bit(a, 16'd1, r, t - 1);
		return r;
	endfunction

	function automatic logic [7:0] alu_dec(input logic [7:0] a);
		logic [15:0] r;
		r = {8'h00, a - 8'd1};
		set_zn(r, 1'b0);
		cc_r[FV] = borrow_bit({8'h00, a}, 16'd1, r, 7) ^ borrow_bit({8'h00, a}, 16'd1, r, 6);
		return r[7:0];
	endfunction

	function automatic logic takes_y(input logic [7:0] op);
		case (op)
			OP_RRWA, OP_RLWA, OP_SRLW, OP_INCW, OP_CLRW, OP_POPW, OP_PUSHW, OP_LDW_SPX,
			OP_LDW_XSP, OP_LD_XL, OP_CPW_IMM, OP_LDW_IMM, OP_CPW_SHORT, OP_LDW_SHORT,
			OP_STW_SHORT, OP_LDW_LONG, OP_AND_IXB, OP_LDW_IXB, OP_AND_IX, OP_LD_IX,
			OP_ST_IX: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic execute_instr(input instr_t ins);
		int unsigned len, ea, npc, v;
		logic [15:0] imm, xi, r;
		logic [7:0] msk;
		logic jump, bad, take;
		cpu_view_t res;
		len = (ins.pre != PRE_NONE) ? 2 : 1;
		imm = {ins.b1, ins.b2};
		jump = 1'b0;
		bad = 1'b0;
		npc = 0;
		xi = (ins.pre == PRE_Y) ? iy_r : ix_r;
		ea = sp_r + ins.b1;
		if (ins.pre == 2'd3 || (ins.pre == PRE_Y && !takes_y(ins.op))) begin
			bad = 1'b1;
		end else if (ins.pre == PRE_EXT) begin
			if (ins.op[7:4] == BIT_GROUP) begin
				msk = 8'd1 << ins.op[3:1];
				v = ram_rd(imm);
				ram_wr(imm, ins.op[0] ? (v[7:0] & ~msk) : (v[7:0] | msk));
				len += 2;
			end else if (ins.op == OP_CLRW) begin
				cc_r[FZ] = 1'b1;
				cc_r[FN] = 1'b0;
				ram_wr(imm, 8'h00);
				len += 2;
			end else begin
				bad = 1'b1;
			end
		end else begin
			case (ins.op)
				OP_RRWA: begin
					r = {acc_r, xi[15:8]};
					set_zn(r, 1'b1);
					acc_r = xi[7:0];
					xi = r;
				end
				OP_RLWA: begin
					r = {xi[7:0], acc_r};
					set_zn(r, 1'b1);
					acc_r = xi[15:8];
					xi = r;
				end
				OP_SRL_SP, OP_RRC_SP: begin
					v = ram_rd(ea);
					r = {8'h00, (ins.op == OP_RRC_SP) ? cc_r[FC] : 1'b0, v[7:1]};
					cc_r[FC] = v[0];
					set_zn(r, 1'b0);
					ram_wr(ea, r[7:0]);
					len += 1;
				end
				OP_INC_SP: begin
					r = alu_inc({8'h00, ram_rd(ea)}, 1'b0);
					ram_wr(ea, r[7:0]);
					len += 1;
				end
				OP_CLR_SP: begin
					cc_r[FZ] = 1'b1;
					cc_r[FN] = 1'b0;
					ram_wr(ea, 8'h00);
					len += 1;
				end
				OP_CP_SP: begin
					alu_cmp({8'h00, acc_r}, {8'h00, ram_rd(ea)}, 1'b0);
					len += 1;
				end
				OP_CPW_SP: begin
					alu_cmp(xi, ram_rd16(ea), 1'b1);
					len += 1;
				end
				OP_XOR_SP: begin
					acc_r ^= ram_rd(ea);
					set_zn({8'h00, acc_r}, 1'b0);
					len += 1;
				end
				OP_OR_SP: begin
					acc_r |= ram_rd(ea);
					set_zn({8'h00, acc_r}, 1'b0);
					len += 1;
				end
				OP_ADD_SP: begin
					r = alu_add({8'h00, acc_r}, {8'h00, ram_rd(ea)}, 1'b0);
					acc_r = r[7:0];
					len += 1;
				end
				OP_ADDW_IMM: begin
					xi = alu_add(xi, imm, 1'b1);
					len += 2;
				end
				OP_LDW_SP: begin
					xi = ram_rd16(ea);
					set_zn(xi, 1'b1);
					len += 1;
				end
				OP_STW_SP: begin
					set_zn(xi, 1'b1);
					ram_wr16(ea, xi);
					len += 1;
				end
				OP_JRA, OP_JRNC, OP_JRC, OP_JRNE, OP_JREQ: begin
					take = (ins.op == OP_JRA) || (ins.op == OP_JRNC && !cc_r[FC]) ||
						(ins.op == OP_JRC && cc_r[FC]) || (ins.op == OP_JRNE && !cc_r[FZ]) ||
						(ins.op == OP_JREQ && cc_r[FZ]);
					len += 1;
					if (take) begin
						npc = pc_r + len + {{24{ins.b1[7]}}, ins.b1};
						jump = 1'b1;
					end
				end
				OP_CPL: begin
					acc_r = ~acc_r;
					cc_r[FC] = 1'b1;
					set_zn({8'h00, acc_r}, 1'b0);
				end
				OP_DEC: acc_r = alu_dec(acc_r);
				OP_PUSH_IMM: begin
					push_byte(ins.b1);
					len += 1;
				end
				OP_TNZ: set_zn({8'h00, acc_r}, 1'b0);
				OP_SUBSP: begin
					sp_r = sp_r - ins.b1;
					len += 1;
				end
				OP_SRLW: begin
					cc_r[FC] = xi[0];
					xi = xi >> 1;
					set_zn(xi, 1'b1);
				end
				OP_ADDSP: begin
					sp_r = sp_r + ins.b1;
					len += 1;
				end
				OP_INCW: xi = alu_inc(xi, 1'b1);
				OP_CLRW: begin
					cc_r[FZ] = 1'b1;
					cc_r[FN] = 1'b0;
					xi = 16'h0000;
				end
				OP_ST_SP: begin
					set_zn({8'h00, acc_r}, 1'b0);
					ram_wr(ea, acc_r);
					len += 1;
				end
				OP_LD_SP: begin
					acc_r = ram_rd(ea);
					set_zn({8'h00, acc_r}, 1'b0);
					len += 1;
				end
				OP_RET: begin
					v = pc_r + len;
					npc = {v[23:16], pop_word()};
					jump = 1'b1;
				end
				OP_INT, OP_JPF: begin
					npc = {ins.b1, ins.b2, ins.b3};
					jump = 1'b1;
				end
				OP_POP_A: acc_r = pop_byte();
				OP_POPW: xi = pop_word();
				OP_PUSH_A: push_byte(acc_r);
				OP_PUSHW: push_word(xi);
				OP_LDW_SPX: sp_r = xi;
				OP_LDW_XSP: xi = sp_r;
				OP_LD_XL: xi = {xi[15:8], acc_r};
				OP_SIM: begin
					cc_r[FI0] = 1'b1;
					cc_r[FI1] = 1'b1;
				end
				OP_CP_IMM: begin
					alu_cmp({8'h00, acc_r}, {8'h00, ins.b1}, 1'b0);
					len += 1;
				end
				OP_CPW_IMM: begin
					alu_cmp(xi, imm, 1'b1);
					len += 2;
				end
				OP_BCP_IMM: begin
					set_zn({8'h00, acc_r & ins.b1}, 1'b0);
					len += 1;
				end
				OP_LD_IMM: begin
					acc_r = ins.b1;
					set_zn({8'h00, acc_r}, 1'b0);
					len += 1;
				end
				OP_XOR_IMM: begin
					acc_r ^= ins.b1;
					set_zn({8'h00, acc_r}, 1'b0);
					len += 1;
				end
				OP_OR_IMM: begin
					acc_r |= ins.b1;
					set_zn({8'h00, acc_r}, 1'b0);
					len += 1;
				end
				OP_LDW_IMM: begin
					xi = imm;
					set_zn(xi, 1'b1);
					len += 2;
				end
				OP_CPW_SHORT: begin
					alu_cmp(xi, ram_rd16(ins.b1), 1'b1);
					len += 1;
				end
				OP_LD_SHORT: begin
					acc_r = ram_rd(ins.b1);
					set_zn({8'h00, acc_r}, 1'b0);
					len += 1;
				end
				OP_LDW_SHORT: begin
					xi = ram_rd16(ins.b1);
					set_zn(xi, 1'b1);
					len += 1;
				end
				OP_STW_SHORT: begin
					set_zn(xi, 1'b1);
					ram_wr16(ins.b1, xi);
					len += 1;
				end
				OP_LD_LONG: begin
					acc_r = ram_rd(imm);
					set_zn({8'h00, acc_r}, 1'b0);
					len += 2;
				end
				OP_ST_LONG: begin
					set_zn({8'h00, acc_r}, 1'b0);
					ram_wr(imm, acc_r);
					len += 2;
				end
				OP_CALL: begin
					len += 2;
					v = (pc_r + len) & 32'hFFFFFF;
					push_word(v[15:0]);
					npc = {v[23:16], imm};
					jump = 1'b1;
				end
				OP_LDW_LONG: begin
					xi = ram_rd16(imm);
					set_zn(xi, 1'b1);
					len += 2;
				end
				OP_AND_IXB: begin
					acc_r &= ram_rd(xi + ins.b1);
					set_zn({8'h00, acc_r}, 1'b0);
					len += 1;
				end
				OP_ST_IXB: begin
					set_zn({8'h00, acc_r}, 1'b0);
					ram_wr(xi + ins.b1, acc_r);
					len += 1;
				end
				OP_LDW_IXB: begin
					xi = ram_rd16(xi + ins.b1);
					set_zn(xi, 1'b1);
					len += 1;
				end
				OP_AND_IX: begin
					acc_r &= ram_rd(xi);
					set_zn({8'h00, acc_r}, 1'b0);
				end
				OP_LD_IX: begin
					acc_r = ram_rd(xi);
					set_zn({8'h00, acc_r}, 1'b0);
				end
				OP_ST_IX: begin
					set_zn({8'h00, acc_r}, 1'b0);
					ram_wr(xi, acc_r);
				end
				default: bad = 1'b1;
			endcase
			if (ins.pre == PRE_Y) begin
				iy_r = xi;
			end else begin
				ix_r = xi;
			end
		end
		if (!bad) begin
			pc_r = jump ? npc[23:0] : pc_r + len[23:0];
		end
		res.pc = pc_r;
		res.a = acc_r;
		res.x = ix_r;
		res.y = iy_r;
		res.sp = sp_r;
		res.cc = cc_r;
		res.bad = bad;
		cpu_state_q.push_back(res);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cpu_view_t want;
		if (!arst_n) begin
			boot_pc = RESET_PC;
			pc_r = RESET_PC;
			acc_r = '0;
			ix_r = '0;
			iy_r = '0;
			sp_r = '0;
			cc_r = '0;
			foreach (ram[i]) begin
				ram[i] = 8'h00;
			end
			cpu_state_q.delete();
		end else begin
			if (result_valid && !result_stall) begin
				if (cpu_state_q.size() == 0) begin
					report_mismatch("unexpected result word", 1, 0);
				end else begin
					want = cpu_state_q.pop_front();
					if (next_pc !== want.pc) report_mismatch("next_pc", next_pc, want.pc);
					if (acc_value !== want.a) report_mismatch("acc_value", acc_value, want.a);
					if (x_value !== want.x) report_mismatch("x_value", x_value, want.x);
					if (y_value !== want.y) report_mismatch("y_value", y_value, want.y);
					if (sp_value !== want.sp) report_mismatch("sp_value", sp_value, want.sp);
					if (flags_value !== want.cc)
						report_mismatch("flags_value", flags_value, want.cc);
					if (bad_opcode !== want.bad)
						report_mismatch("bad_opcode", bad_opcode, want.bad);
				end
			end
			if (cfg_valid && cfg_ready) begin
				boot_pc = cfg_data;
				pc_r = cfg_data;
			end
			if (item_valid && !item_stall) begin
				execute_instr({prefix_code, opcode, operand_byte_one, operand_byte_two,
					operand_byte_three});
			end
		end
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import ecx_pkg::*;

	localparam logic [7:0] OPC_PREFIX_EXT = 8'h72;
	localparam logic [7:0] OPC_PREFIX_Y = 8'h90;

	localparam logic [7:0] MAIN_OPS [62] = '{
		OP_RRWA, OP_RLWA, OP_SRL_SP, OP_RRC_SP, OP_INC_SP, OP_CLR_SP, OP_CP_SP,
		OP_CPW_SP, OP_XOR_SP, OP_OR_SP, OP_ADD_SP, OP_ADDW_IMM, OP_LDW_SP, OP_STW_SP,
		OP_JRA, OP_JRNC, OP_JRC, OP_JRNE, OP_JREQ, OP_CPL, OP_DEC, OP_PUSH_IMM,
		OP_TNZ, OP_SUBSP, OP_SRLW, OP_ADDSP, OP_INCW, OP_CLRW, OP_ST_SP, OP_LD_SP,
		OP_RET, OP_INT, OP_POP_A, OP_POPW, OP_PUSH_A, OP_PUSHW, OP_LDW_SPX,
		OP_LDW_XSP, OP_LD_XL, OP_SIM, OP_CP_IMM, OP_CPW_IMM, OP_BCP_IMM, OP_LD_IMM,
		OP_XOR_IMM, OP_OR_IMM, OP_JPF, OP_LDW_IMM, OP_CPW_SHORT, OP_LD_SHORT,
		OP_LDW_SHORT, OP_STW_SHORT, OP_LD_LONG, OP_ST_LONG, OP_CALL, OP_LDW_LONG,
		OP_AND_IXB, OP_ST_IXB, OP_LDW_IXB, OP_AND_IX, OP_LD_IX, OP_ST_IX
	};

	localparam logic [7:0] Y_OPS [21] = '{
		OP_RRWA, OP_RLWA, OP_SRLW, OP_INCW, OP_CLRW, OP_POPW, OP_PUSHW, OP_LDW_SPX,
		OP_LDW_XSP, OP_LD_XL, OP_CPW_IMM, OP_LDW_IMM, OP_CPW_SHORT, OP_LDW_SHORT,
		OP_STW_SHORT, OP_LDW_LONG, OP_AND_IXB, OP_LDW_IXB, OP_AND_IX, OP_LD_IX, OP_ST_IX
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [23:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  prefix_code = '0;
	logic [7:0]  opcode = '0;
	logic [7:0]  operand_byte_one = '0;
	logic [7:0]  operand_byte_two = '0;
	logic [7:0]  operand_byte_three = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [23:0] next_pc;
	logic [7:0]  acc_value;
	logic [15:0] x_value;
	logic [15:0] y_value;
	logic [15:0] sp_value;
	logic [7:0]  flags_value;
	logic        bad_opcode;
	int          mismatches;
	int          outstanding;
	logic        item_took = 1'b0;
	logic        cfg_took = 1'b0;
	logic        calm = 1'b0;
	int          hold_cycles = 0;

	always #6 clk = ~clk;

	eight_bit_cpu_execute dut (.*);
	ecx_execute_checker checker_i (.*);

	always @(posedge clk) begin
		item_took <= item_valid && !item_stall;
		cfg_took <= cfg_valid && cfg_ready;
	end

	// receiver side stall, with a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				result_stall = 1'b1;
				hold_cycles--;
			end else begin
				result_stall = !calm && ($urandom_range(99) < 35);
			end
		end
	end

	task automatic write_reset_pc(input logic [23:0] val);
		cfg_valid = 1'b1;
		cfg_data = val;
		do @(negedge clk); while (!cfg_took);
		cfg_valid = 1'b0;
	endtask

	task automatic send_word(input logic [1:0] pre, input logic [7:0] op,
			input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
		if (!calm && $urandom_range(99) < 35) begin
			item_valid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		item_valid = 1'b1;
		prefix_code = pre;
		opcode = op;
		operand_byte_one = b1;
		operand_byte_two = b2;
		operand_byte_three = b3;
		do @(negedge clk); while (!item_took);
	endtask

	task automatic drain();
		item_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		return ($urandom_range(99) < 60) ? 8'($urandom) : 8'($urandom_range(3));
	endfunction

	task automatic send_random();
		int sel;
		logic [1:0] pre;
		logic [7:0] op;
		sel = $urandom_range(99);
		if (sel < 72) begin
			pre = PRE_NONE;
			op = MAIN_OPS[$urandom_range(61)];
		end else if (sel < 84) begin
			pre = PRE_Y;
			op = Y_OPS[$urandom_range(20)];
		end else if (sel < 92) begin
			pre = PRE_EXT;
			op = ($urandom_range(7) == 0) ? OP_CLRW : {BIT_GROUP, 4'($urandom)};
		end else begin
			pre = 2'($urandom);
			op = 8'($urandom);
		end
		send_word(pre, op, pick_byte(), pick_byte(), pick_byte());
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		write_reset_pc(24'hFFFFFF);
		send_word(PRE_NONE, OP_LD_IMM, 8'h80, 8'h00, 8'h00);
		send_word(PRE_NONE, OP_LD_IMM, 8'h00, 8'hFF, 8'hFF);
		send_word(PRE_NONE, OP_JRA, 8'h7F, 8'h00, 8'h00);
		send_word(PRE_NONE, OP_JRA, 8'h80, 8'h00, 8'h00);
		send_word(2'd3, OP_LD_IMM, 8'hFF, 8'hFF, 8'hFF);
		send_word(PRE_NONE, OPC_PREFIX_EXT, 8'h00, 8'h00, 8'h00);
		send_word(PRE_NONE, OPC_PREFIX_Y, 8'h00, 8'h00, 8'h00);
		send_word(PRE_Y, OP_LD_IMM, 8'h01, 8'h00, 8'h00);
		send_word(PRE_EXT, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(PRE_NONE, OP_LDW_IMM, 8'hFF, 8'hFF, 8'h00);
		send_word(PRE_NONE, OP_PUSHW, 8'h00, 8'h00, 8'h00);
		send_word(PRE_Y, OP_LDW_IMM, 8'h80, 8'h00, 8'h00);
		send_word(PRE_Y, OP_PUSHW, 8'h00, 8'h00, 8'h00);
		send_word(PRE_NONE, OP_POPW, 8'h00, 8'h00, 8'h00);
		send_word(PRE_NONE, OP_SRL_SP, 8'h01, 8'h00, 8'h00);
		send_word(PRE_NONE, OP_CALL, 8'h12, 8'h34, 8'h00);
		send_word(PRE_NONE, OP_RET, 8'h00, 8'h00, 8'h00);
		send_word(PRE_NONE, OP_ADDW_IMM, 8'hFF, 8'hFF, 8'h00);
		send_word(PRE_NONE, OP_AND_IXB, 8'hFF, 8'h00, 8'h00);
		send_word(PRE_NONE, OP_ADD_SP, 8'hFF, 8'h00, 8'h00);
		send_word(PRE_EXT, 8'h11, 8'hFF, 8'hFF, 8'h00);
		send_word(PRE_EXT, OP_CLRW, 8'hFF, 8'hFF, 8'h00);
		send_word(PRE_NONE, OP_INT, 8'hFF, 8'hFF, 8'hFF);
		send_word(PRE_NONE, OP_JPF, 8'h00, 8'h00, 8'h00);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_reset_pc(24'h000000);
				1: write_reset_pc(24'($urandom));
				2: write_reset_pc(24'hFFFFFF);
				default: write_reset_pc(RESET_PC);
			endcase
			for (int n = 0; n < 500; n++) begin
				calm = (phase == 1 && n >= 100 && n < 350);
				if (phase == 0 && n == 200) begin
					hold_cycles = 300;
				end
				if (phase == 2 && n == 250) begin
					drain();
				end
				send_random();
			end
			calm = 1'b0;
			drain();
		end

		repeat (20) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("eight_bit_cpu_execute test passed");
		end else begin
			$display("eight_bit_cpu_execute test failed");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("eight_bit_cpu_execute test failed");
		$finish;
	end

endmodule
